// File: hw/rtl/sparse_covariance_transform_defines.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef SPARSE_COVARIANCE_TRANSFORM_DEFINES_SVH
`define SPARSE_COVARIANCE_TRANSFORM_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SCT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// File: hw/rtl/sct_pkg.sv
// Shared types and constants for the sparse covariance transform.
// No dependencies.
package sct_pkg;
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_LOAD  = 2'd1,
    OP_ADD   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZDEN  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_WR1, S_RD2, S_WR2, S_DIV, S_DIVFIN, S_READ, S_DONE
  } state_t;

  localparam logic [0:0] REG_SIZE    = 1'b0;
  localparam logic [0:0] REG_POISSON = 1'b1;
  localparam logic [63:0] MIN64 = 64'h8000000000000000;
  localparam logic [63:0] MAX64 = 64'h7fffffffffffffff;
endpackage

// File: hw/rtl/sct_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module sct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: hw/rtl/sct_divider.sv
// Restoring divider for the binomial variance: quotient of a 96-bit square by d.
// Depends on nothing; one quotient bit per cycle.
module sct_divider (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [95:0]  dividend,
  input  logic [47:0]  divisor,
  output logic         done,
  output logic [95:0]  quotient
);
  logic [48:0] rem;
  logic [95:0] shreg;
  logic [6:0]  count;
  logic        running;
  logic [48:0] trial;

  always_comb begin
    trial = {rem[47:0], shreg[95]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= 7'd0;
        rem     <= '0;
        shreg   <= dividend;
      end else if (running) begin
        shreg <= {shreg[94:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem      <= trial - {1'b0, divisor};
          quotient <= {quotient[94:0], 1'b1};
        end else begin
          rem      <= trial;
          quotient <= {quotient[94:0], 1'b0};
        end
        count <= count + 7'd1;
        if (count == 7'd95) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/sparse_covariance_transform.sv
// Sparse covariance transform top level: sigma store, variance store, control.
// Depends on sct_pkg, sct_ram and sct_divider.
//
// Usage: pulse start with an operation while busy is low; the block raises busy
// and, when done, shows value and status for one cycle with done high.
// Path from the accepting edge to the done cycle: write covariance and Poisson
// load go S_RD1, S_DONE; read entry adds S_READ (one registered sigma read).
// Add triple: S_WR1 and S_RD2 on the diagonal, then S_WR2 and S_DIVFIN off
// it, as each sigma entry takes a read, then a write through one memory port.
// Binomial load: S_DIV builds the square of n from three 24x24 partial products,
// then the bit-serial divider yields one quotient bit per cycle during S_DIVFIN.
// One operation is in flight at a time; busy falls the cycle after done, so a
// new transaction is accepted at the earliest in the cycle after the done cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// must come while busy is low. Reset clears control state and loads
// size_in_use = 64, poisson_mode = 1; memory contents are undefined until
// written. The receiver cannot stall: done lasts exactly one cycle.
module sparse_covariance_transform #(
  parameter int MAX_DIM     = 64,
  parameter int MAX_COLUMNS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [5:0]  row_a,
  input  logic [5:0]  row_b,
  input  logic [7:0]  column,
  input  logic signed [63:0] cov_value,
  input  logic [47:0] numerator,
  input  logic [47:0] denominator,
  output logic        done,
  output logic signed [63:0] value,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam int DW = $clog2(MAX_DIM);
  localparam int SW = 2 * DW;
  localparam int CW = $clog2(MAX_COLUMNS);

  sct_pkg::state_t state, state_next;
  logic [6:0]  size_in_use;
  logic        poisson_mode;

  logic [1:0]  op;
  logic [5:0]  ra, rb;
  logic [7:0]  col;
  logic [63:0] cov;
  logic [47:0] num, den;
  logic        sat;
  logic [1:0]  stat;
  logic [63:0] var_hold;
  logic [63:0] res_value;

  logic [SW-1:0] s_addr;
  logic          s_we;
  logic [63:0]   s_wdata, s_rdata;
  logic [CW-1:0] v_addr;
  logic          v_we;
  logic [63:0]   v_wdata, v_rdata;

  logic [95:0] sq;
  logic [47:0] pp_ll, pp_lh, pp_hh;
  logic [1:0]  sq_step;
  logic        div_start, div_done;
  logic [95:0] quo;

  int          m_eff;
  logic        rows_ok, col_ok;
  logic [63:0] sum;
  logic        sum_ovf;
  logic [63:0] sum_sat;
  logic [63:0] bin_var;
  logic        bin_sat;

  // Effective dimension and index checks, taken from the accepted inputs.
  always_comb begin
    m_eff   = (int'(size_in_use) < MAX_DIM) ? int'(size_in_use) : MAX_DIM;
    rows_ok = (int'(row_a) < m_eff) && (int'(row_b) < m_eff);
    col_ok  = int'(column) < MAX_COLUMNS;
  end

  always_comb begin
    sum     = s_rdata + var_hold;
    sum_ovf = (s_rdata[63] == var_hold[63]) && (sum[63] != s_rdata[63]);
    sum_sat = sum_ovf ? (s_rdata[63] ? sct_pkg::MIN64 : sct_pkg::MAX64) : sum;
  end

  // Binomial variance from the quotient: n - q, saturating at the minimum.
  always_comb begin
    bin_sat = 1'b0;
    bin_var = {16'b0, num} - quo[63:0];
    if (quo[95:64] != '0) begin
      bin_sat = 1'b1;
      bin_var = sct_pkg::MIN64;
    end else if (quo[63:0] > {16'b0, num} && (quo[63:0] - {16'b0, num}) > sct_pkg::MIN64) begin
      bin_sat = 1'b1;
      bin_var = sct_pkg::MIN64;
    end
  end

  sct_ram #(.WIDTH(64), .DEPTH(1 << SW)) u_sigma (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );

  sct_ram #(.WIDTH(64), .DEPTH(MAX_COLUMNS)) u_var (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
  );

  sct_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sq), .divisor(den),
    .done(div_done), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use  <= 7'd64;
      poisson_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        sct_pkg::REG_SIZE:    size_in_use  <= cfg_data;
        sct_pkg::REG_POISSON: poisson_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sct_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the transaction and classify it at acceptance.
  always_ff @(posedge clk) begin
    if (state == sct_pkg::S_IDLE && start) begin
      op   <= operation;
      ra   <= row_a;
      rb   <= row_b;
      col  <= column;
      cov  <= cov_value;
      num  <= numerator;
      den  <= denominator;
      sat  <= 1'b0;
      stat <= sct_pkg::ST_OK;
      if (operation == sct_pkg::OP_LOAD) begin
        if (!col_ok) begin
          stat <= sct_pkg::ST_RANGE;
        end else if (!poisson_mode && denominator == '0) begin
          stat <= sct_pkg::ST_ZDEN;
        end
      end else if (!rows_ok || (operation == sct_pkg::OP_ADD && !col_ok)) begin
        stat <= sct_pkg::ST_RANGE;
      end
      sq_step <= 2'd0;
    end
    // Variance read issued in S_RD1 shows up here.
    if (state == sct_pkg::S_WR1 && op == sct_pkg::OP_ADD) begin
      var_hold <= v_rdata;
    end
    if ((state == sct_pkg::S_RD2 ||
         (state == sct_pkg::S_DIVFIN && op == sct_pkg::OP_ADD)) && sum_ovf) begin
      sat <= 1'b1;
    end
    if (state == sct_pkg::S_DIVFIN && op == sct_pkg::OP_LOAD && div_done && bin_sat) begin
      sat <= 1'b1;
    end
    // Square n in S_DIV, one 24x24 partial product per sq_step.
    if (state == sct_pkg::S_DIV) begin
      sq_step <= sq_step + 2'd1;
      case (sq_step)
        2'd0: pp_ll <= num[23:0] * num[23:0];
        2'd1: pp_lh <= num[23:0] * num[47:24];
        2'd2: pp_hh <= num[47:24] * num[47:24];
        default: ;
      endcase
    end
    if (state == sct_pkg::S_READ) begin
      res_value <= s_rdata;
    end
  end

  always_comb begin
    sq = {pp_hh, 48'b0} + {23'b0, pp_lh, 25'b0} + {48'b0, pp_ll};
  end

  always_comb begin
    state_next = state;
    busy       = (state != sct_pkg::S_IDLE);
    s_we       = 1'b0;
    s_addr     = {DW'(rb), DW'(ra)};
    s_wdata    = sum_sat;
    v_we       = 1'b0;
    v_addr     = CW'(col);
    v_wdata    = {16'b0, num};
    div_start  = 1'b0;
    done       = 1'b0;
    value      = '0;
    status     = stat;
    case (state)
      sct_pkg::S_IDLE: begin
        if (start) begin
          state_next = sct_pkg::S_RD1;
        end
      end
      sct_pkg::S_RD1: begin
        // Sigma read of entry (rb, ra), or (ra, rb) for a read op, and variance read issued here.
        if (stat != sct_pkg::ST_OK) begin
          state_next = sct_pkg::S_DONE;
        end else begin
          case (op)
            sct_pkg::OP_WRITE: begin
              s_we       = 1'b1;
              s_addr     = {DW'(ra), DW'(rb)};
              s_wdata    = cov;
              state_next = sct_pkg::S_DONE;
            end
            sct_pkg::OP_LOAD: begin
              if (poisson_mode) begin
                v_we       = 1'b1;
                state_next = sct_pkg::S_DONE;
              end else begin
                state_next = sct_pkg::S_DIV;
              end
            end
            sct_pkg::OP_ADD: state_next = sct_pkg::S_WR1;
            default: begin
              s_addr     = {DW'(ra), DW'(rb)};
              state_next = sct_pkg::S_READ;
            end
          endcase
        end
      end
      sct_pkg::S_WR1: begin
        // Wait for the variance register to load, then write in S_RD2.
        state_next = sct_pkg::S_RD2;
      end
      sct_pkg::S_RD2: begin
        s_we = 1'b1;
        state_next = (ra == rb) ? sct_pkg::S_DONE : sct_pkg::S_WR2;
      end
      sct_pkg::S_WR2: begin
        s_addr     = {DW'(ra), DW'(rb)};
        state_next = sct_pkg::S_DIVFIN;
      end
      sct_pkg::S_DIVFIN: begin
        if (op == sct_pkg::OP_ADD) begin
          s_addr     = {DW'(ra), DW'(rb)};
          s_we       = 1'b1;
          state_next = sct_pkg::S_DONE;
        end else if (div_done) begin
          v_we       = 1'b1;
          v_wdata    = bin_var;
          state_next = sct_pkg::S_DONE;
        end
      end
      sct_pkg::S_DIV: begin
        if (sq_step == 2'd3) begin
          div_start  = 1'b1;
          state_next = sct_pkg::S_DIVFIN;
        end
      end
      sct_pkg::S_READ: begin
        state_next = sct_pkg::S_DONE;
      end
      sct_pkg::S_DONE: begin
        done       = 1'b1;
        value      = (op == sct_pkg::OP_READ && stat == sct_pkg::ST_OK) ? res_value : '0;
        status     = sat ? sct_pkg::ST_SAT : stat;
        state_next = sct_pkg::S_IDLE;
      end
      default: state_next = sct_pkg::S_IDLE;
    endcase
  end
endmodule

// File: hw/rtl/sct_checker.sv
// Port-level checks for the sparse covariance transform.
// Depends on sparse_covariance_transform_defines.svh and sct_pkg; bound to the top level.
`include "sparse_covariance_transform_defines.svh"
module sct_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [63:0] value
);
  `SCT_ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy, busy)
  `SCT_ASSERT_IMP(a_done_busy, clk, rst, done, busy)
  `SCT_ASSERT_NEXT(a_idle_after_done, clk, rst, done, !busy && !done)
  `SCT_ASSERT_IMP(a_value_zero_bad, clk, rst, done && status != sct_pkg::ST_OK, value == 64'd0)
endmodule

bind sparse_covariance_transform sct_checker u_sct_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .value(value)
);
